### rtl/psra_pkg.sv
// psra_pkg: status codes, operation codes and register indexes of the per-sensor
// running average unit. No dependencies; imported by the top level and its checkers.
package psra_pkg;

   localparam int STATUS_W = 3;

   localparam logic [STATUS_W-1:0] STAT_MAP_STORED = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FILLING    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_UPDATED    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_UNKNOWN    = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd4;

   localparam logic OP_MAP    = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic CSR_LOW_LIMIT  = 1'b0;
   localparam logic CSR_HIGH_LIMIT = 1'b1;

   localparam logic signed [15:0] LOW_LIMIT_RESET  = 16'sd0;
   localparam logic signed [15:0] HIGH_LIMIT_RESET = 16'sd7680;

endpackage

### rtl/psra_mean_div.sv
// psra_mean_div: signed window sum divided by WINDOW, truncated toward zero.
// Two register stages: reciprocal multiply, then one-step correction and sign.
// No package dependencies.
module psra_mean_div #(
   parameter int WINDOW = 8,
   parameter int SUMW   = 19
) (
   input  logic                   clock,
   input  logic signed [SUMW-1:0] sum,
   output logic        [15:0]     average
);

   localparam int MAGW  = SUMW;
   localparam int SHIFT = SUMW;
   localparam int PRODW = MAGW + SHIFT + 1;
   localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'((64'd1 << SHIFT) / WINDOW);

   logic [MAGW-1:0]  mag;
   logic [PRODW-1:0] prod_in;
   logic [PRODW-1:0] prod_ff;
   logic [MAGW-1:0]  mag_ff;
   logic             neg_ff;
   logic [MAGW-1:0]  q0;
   logic [MAGW-1:0]  qw;
   logic [MAGW-1:0]  rem;
   logic [MAGW-1:0]  quot;
   logic [15:0]      average_in;
   logic [15:0]      average_ff;

   always_comb begin
      mag     = sum[SUMW-1] ? MAGW'(-sum) : MAGW'(sum);
      prod_in = PRODW'(mag) * PRODW'(RECIP);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      mag_ff  <= mag;
      neg_ff  <= sum[SUMW-1];
   end

   // q0 is the true quotient or one below it
   always_comb begin
      q0         = prod_ff[SHIFT +: MAGW];
      qw         = q0 * MAGW'(WINDOW);
      rem        = mag_ff - qw;
      quot       = (rem >= MAGW'(WINDOW)) ? q0 + MAGW'(1) : q0;
      average_in = neg_ff ? -quot[15:0] : quot[15:0];
   end

   always_ff @(posedge clock) begin
      average_ff <= average_in;
   end

   assign average = average_ff;

endmodule

### rtl/per_sensor_running_average_unit.sv
// per_sensor_running_average_unit: sensor table with per-sensor moving average and alarm.
// Depends on psra_pkg and psra_mean_div.
//
// Usage:
//   Input beats are commands: one is taken at a clock edge where start is high and
//   busy is low. req_operation 0 appends a sensor-to-room entry; 1 delivers a sample.
//   Every command yields exactly one result beat: rsp_valid is high for one cycle
//   with the rsp_ fields; the receiver cannot stall and must take it then.
//   Map commands, and samples while the table is empty, finish in the accept cycle:
//   busy stays low and the result shows in the next cycle.
//   A sample scans the sensor record memory one entry a cycle. A sample that hits
//   entry k keeps busy high through the scan up to entry k, window read, multiply,
//   correction and write-back; its result shows in the first cycle busy is low again.
//   A sample for an unknown sensor keeps busy high while it scans every loaded entry.
//   The record scan sets the rate; a new command may be taken while a result shows.
//   Limits are written on the csr_ port at any edge with csr_write high and reset low.
//   Synchronous reset empties the table and restores the limits; no clearing pass.
module per_sensor_running_average_unit
   import psra_pkg::*;
#(
   parameter int MAX_SENSORS = 16,
   parameter int WINDOW      = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [15:0]         req_sensor_id,
   input  logic [15:0]         req_room_id,
   input  logic signed [15:0]  req_sample_value,
   input  logic [31:0]         req_sample_time,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [15:0]         rsp_room_of_sensor,
   output logic signed [15:0]  rsp_average,
   output logic                rsp_too_hot,
   output logic                rsp_too_cold,
   output logic [31:0]         rsp_last_time,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata
);

   localparam int SLW   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
   localparam int CW    = $clog2(MAX_SENSORS + 1);
   localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUMW  = 16 + $clog2(WINDOW);
   localparam int WDEP  = MAX_SENSORS * WINDOW;
   localparam int WAW   = (WDEP > 1) ? $clog2(WDEP) : 1;

   typedef struct packed {
      logic [15:0]            key;
      logic [15:0]            room;
      logic                   full;
      logic [PW-1:0]          pos;
      logic signed [SUMW-1:0] sum;
      logic [15:0]            avg;
      logic [31:0]            stamp;
   } rec_type;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SCAN = 6'b000010,
      S_WIN  = 6'b000100,
      S_MUL  = 6'b001000,
      S_CORR = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   rec_type            rec_mem [MAX_SENSORS];
   logic signed [15:0] win_mem [WDEP];

   state_type              state_ff, state_in;
   logic [CW-1:0]          loaded_ff, loaded_in;
   logic [SLW-1:0]         scan_idx_ff, scan_idx_in;
   logic signed [15:0]     low_limit_ff, high_limit_ff;
   logic [15:0]            sid_ff, val_ff;
   logic [31:0]            ts_ff;
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic                   sum_load;

   logic                   rec_rd_en, rec_we;
   logic [SLW-1:0]         rec_raddr, rec_waddr;
   rec_type                rec_rd_ff, rec_wdata;
   logic                   win_rd_en, win_we;
   logic [WAW-1:0]         win_raddr, win_waddr;
   logic signed [15:0]     win_rd_ff;

   logic                   rsp_valid_ff, rsp_load;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]            rsp_room_ff, rsp_room_in;
   logic [15:0]            rsp_avg_ff, rsp_avg_in;
   logic                   rsp_hot_ff, rsp_hot_in;
   logic                   rsp_cold_ff, rsp_cold_in;
   logic [31:0]            rsp_time_ff, rsp_time_in;

   logic                   accept, scan_hit, scan_last, pos_last;
   logic [15:0]            div_avg, new_avg;

   psra_mean_div #(
      .WINDOW (WINDOW),
      .SUMW   (SUMW)
   ) u_mean_div (
      .clock   (clock),
      .sum     (sum_ff),
      .average (div_avg)
   );

   assign accept    = start && (state_ff == S_IDLE);
   assign scan_hit  = (rec_rd_ff.key == sid_ff);
   assign scan_last = ((CW'(scan_idx_ff) + CW'(1)) == loaded_ff);
   assign pos_last  = (rec_rd_ff.pos == PW'(WINDOW - 1));
   assign new_avg   = rec_rd_ff.full ? div_avg : rec_rd_ff.avg;

   always_comb begin
      state_in      = state_ff;
      loaded_in     = loaded_ff;
      scan_idx_in   = scan_idx_ff;
      sum_in        = sum_ff;
      sum_load      = 1'b0;
      rec_rd_en     = 1'b0;
      rec_raddr     = scan_idx_ff;
      rec_we        = 1'b0;
      rec_waddr     = scan_idx_ff;
      rec_wdata     = rec_rd_ff;
      win_rd_en     = 1'b0;
      win_raddr     = WAW'(scan_idx_ff * WINDOW + rec_rd_ff.pos);
      win_we        = 1'b0;
      win_waddr     = WAW'(scan_idx_ff * WINDOW + rec_rd_ff.pos);
      rsp_load      = 1'b0;
      rsp_status_in = STAT_UNKNOWN;
      rsp_room_in   = '0;
      rsp_avg_in    = '0;
      rsp_hot_in    = 1'b0;
      rsp_cold_in   = 1'b0;
      rsp_time_in   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_MAP) begin
                  rsp_load = 1'b1;
                  if (loaded_ff >= CW'(MAX_SENSORS)) begin
                     rsp_status_in = STAT_TABLE_FULL;
                  end else begin
                     rec_we        = 1'b1;
                     rec_waddr     = loaded_ff[SLW-1:0];
                     rec_wdata     = '{key: req_sensor_id, room: req_room_id, full: 1'b0,
                                       pos: '0, sum: '0, avg: '0, stamp: '0};
                     loaded_in     = loaded_ff + CW'(1);
                     rsp_status_in = STAT_MAP_STORED;
                     rsp_room_in   = req_room_id;
                  end
               end else if (loaded_ff == '0) begin
                  rsp_load = 1'b1;
               end else begin
                  rec_rd_en   = 1'b1;
                  rec_raddr   = '0;
                  scan_idx_in = '0;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               win_rd_en = 1'b1;
               state_in  = S_WIN;
            end else if (scan_last) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               rec_rd_en   = 1'b1;
               rec_raddr   = scan_idx_ff + SLW'(1);
               scan_idx_in = scan_idx_ff + SLW'(1);
            end
         end
         S_WIN: begin
            sum_load = 1'b1;
            sum_in   = rec_rd_ff.sum + SUMW'($signed(val_ff))
                     - (rec_rd_ff.full ? SUMW'(win_rd_ff) : SUMW'(0));
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_CORR;
         end
         S_CORR: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            rec_we          = 1'b1;
            rec_wdata.full  = rec_rd_ff.full | pos_last;
            rec_wdata.pos   = pos_last ? PW'(0) : rec_rd_ff.pos + PW'(1);
            rec_wdata.sum   = sum_ff;
            rec_wdata.avg   = new_avg;
            rec_wdata.stamp = ts_ff;
            win_we          = 1'b1;
            rsp_load        = 1'b1;
            rsp_status_in   = rec_rd_ff.full ? STAT_UPDATED : STAT_FILLING;
            rsp_room_in     = rec_rd_ff.room;
            rsp_avg_in      = new_avg;
            rsp_hot_in      = rec_rd_ff.full && ($signed(new_avg) > high_limit_ff);
            rsp_cold_in     = rec_rd_ff.full && ($signed(new_avg) < low_limit_ff);
            rsp_time_in     = ts_ff;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         loaded_ff     <= '0;
         low_limit_ff  <= LOW_LIMIT_RESET;
         high_limit_ff <= HIGH_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_load;
         if (csr_write) begin
            case (csr_index)
               CSR_LOW_LIMIT:  low_limit_ff  <= $signed(csr_wdata);
               CSR_HIGH_LIMIT: high_limit_ff <= $signed(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      if (sum_load) begin
         sum_ff <= sum_in;
      end
      if (accept) begin
         sid_ff <= req_sensor_id;
         val_ff <= req_sample_value;
         ts_ff  <= req_sample_time;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_room_ff   <= rsp_room_in;
         rsp_avg_ff    <= rsp_avg_in;
         rsp_hot_ff    <= rsp_hot_in;
         rsp_cold_ff   <= rsp_cold_in;
         rsp_time_ff   <= rsp_time_in;
      end
   end

   // sensor record memory
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      if (rec_rd_en) begin
         rec_rd_ff <= rec_mem[rec_raddr];
      end
   end

   // sample window memory, circular per sensor
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_waddr] <= $signed(val_ff);
      end
      if (win_rd_en) begin
         win_rd_ff <= win_mem[win_raddr];
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_room_of_sensor = rsp_room_ff;
   assign rsp_average        = $signed(rsp_avg_ff);
   assign rsp_too_hot        = rsp_hot_ff;
   assign rsp_too_cold       = rsp_cold_ff;
   assign rsp_last_time      = rsp_time_ff;

endmodule

### rtl/psra_checker.sv
// psra_port_assertions: port-level assertions for per_sensor_running_average_unit.
// Depends on psra_pkg; bound to the top level at the end of this file.
module psra_port_assertions
   import psra_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                req_operation,
   input logic [15:0]         req_room_id,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [15:0]         rsp_room_of_sensor,
   input logic signed [15:0]  rsp_average,
   input logic                rsp_too_hot,
   input logic                rsp_too_cold,
   input logic [31:0]         rsp_last_time
);

   // map beats yield a result in the next cycle, echoing the room when stored
   a_map_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_operation == OP_MAP) |=>
         rsp_valid && ((rsp_status == STAT_TABLE_FULL) ||
                       ((rsp_status == STAT_MAP_STORED) &&
                        (rsp_room_of_sensor == $past(req_room_id)))))
      else $error("map beat without matching result");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STAT_UNKNOWN) || (rsp_status == STAT_TABLE_FULL)) |->
         (rsp_room_of_sensor == 16'd0) && (rsp_average == 16'sd0) && !rsp_too_hot &&
         !rsp_too_cold && (rsp_last_time == 32'd0))
      else $error("rejected beat carries nonzero payload");

   a_filling_no_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STAT_FILLING) || (rsp_status == STAT_MAP_STORED)) |->
         !rsp_too_hot && !rsp_too_cold)
      else $error("alarm raised without updated average");

   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe while busy");

endmodule

bind per_sensor_running_average_unit psra_port_assertions u_psra_checker (.*);

### tb/psra_checker.sv
`timescale 1ns / 100ps
// psra_checker: watches the command and result beats of the running average unit,
// predicts every result from its own copy of the sensor table and limits, and compares.
// Depends on psra_pkg; instantiated by tb_per_sensor_running_average_unit.
module psra_checker
   import psra_pkg::*;
#(
   parameter int MAX_SENSORS = 16,
   parameter int WINDOW      = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_operation,
   input  logic [15:0]         req_sensor_id,
   input  logic [15:0]         req_room_id,
   input  logic signed [15:0]  req_sample_value,
   input  logic [31:0]         req_sample_time,
   input  logic                rsp_valid,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [15:0]         rsp_room_of_sensor,
   input  logic signed [15:0]  rsp_average,
   input  logic                rsp_too_hot,
   input  logic                rsp_too_cold,
   input  logic [31:0]         rsp_last_time,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata,
   output int                  fail_count,
   output int                  pending
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [15:0]         room;
      logic [15:0]         average;
      logic                too_hot;
      logic                too_cold;
      logic [31:0]         stamp;
   } reading_type;

   reading_type expected_readings[$];

   int                 entries_used;
   logic [15:0]        key_tbl   [MAX_SENSORS];
   logic [15:0]        room_tbl  [MAX_SENSORS];
   int                 seen_cnt  [MAX_SENSORS];
   logic signed [15:0] win_tbl   [MAX_SENSORS][WINDOW];
   logic signed [15:0] avg_tbl   [MAX_SENSORS];
   logic [31:0]        stamp_tbl [MAX_SENSORS];
   logic signed [15:0] low_lim;
   logic signed [15:0] high_lim;

   function automatic reading_type predict_reading(input logic is_sample,
                                                   input logic [15:0] sid,
                                                   input logic [15:0] rid,
                                                   input logic signed [15:0] val,
                                                   input logic [31:0] ts);
      reading_type r;
      int          slot;
      int          sum;
      r    = '0;
      slot = -1;
      if (!is_sample) begin
         if (entries_used >= MAX_SENSORS) begin
            r.status = STAT_TABLE_FULL;
         end else begin
            key_tbl[entries_used]   = sid;
            room_tbl[entries_used]  = rid;
            seen_cnt[entries_used]  = 0;
            avg_tbl[entries_used]   = '0;
            stamp_tbl[entries_used] = '0;
            entries_used++;
            r.status = STAT_MAP_STORED;
            r.room   = rid;
         end
      end else begin
         // earliest entry wins on duplicate ids
         for (int i = entries_used - 1; i >= 0; i--) begin
            if (key_tbl[i] == sid) slot = i;
         end
         if (slot < 0) begin
            r.status = STAT_UNKNOWN;
         end else begin
            if (seen_cnt[slot] >= WINDOW) begin
               for (int k = 0; k < WINDOW - 1; k++) win_tbl[slot][k] = win_tbl[slot][k+1];
               win_tbl[slot][WINDOW-1] = val;
               sum = 0;
               for (int k = 0; k < WINDOW; k++) sum += win_tbl[slot][k];
               sum           = sum / WINDOW;
               avg_tbl[slot] = sum[15:0];
               r.status      = STAT_UPDATED;
               r.too_hot     = avg_tbl[slot] > high_lim;
               r.too_cold    = avg_tbl[slot] < low_lim;
            end else begin
               win_tbl[slot][seen_cnt[slot]] = val;
               seen_cnt[slot]++;
               r.status = STAT_FILLING;
            end
            stamp_tbl[slot] = ts;
            r.room    = room_tbl[slot];
            r.average = avg_tbl[slot];
            r.stamp   = stamp_tbl[slot];
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      reading_type want;
      if (reset) begin
         fail_count   = 0;
         entries_used = 0;
         for (int i = 0; i < MAX_SENSORS; i++) begin
            seen_cnt[i]  = 0;
            avg_tbl[i]   = '0;
            stamp_tbl[i] = '0;
         end
         low_lim  = LOW_LIMIT_RESET;
         high_lim = HIGH_LIMIT_RESET;
         expected_readings.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_LOW_LIMIT) low_lim = csr_wdata;
            else high_lim = csr_wdata;
         end
         if (rsp_valid) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: result beat with nothing outstanding, expected none actual status %h",
                        $time, rsp_status);
               fail_count++;
            end else begin
               want = expected_readings.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("room_of_sensor", 32'(want.room), 32'(rsp_room_of_sensor));
               check_field("average", {16'h0000, want.average}, {16'h0000, rsp_average});
               check_field("too_hot", 32'(want.too_hot), 32'(rsp_too_hot));
               check_field("too_cold", 32'(want.too_cold), 32'(rsp_too_cold));
               check_field("last_time", want.stamp, rsp_last_time);
            end
         end
         if (start && !busy) begin
            expected_readings.push_back(predict_reading(req_operation == OP_SAMPLE,
                                                        req_sensor_id, req_room_id,
                                                        req_sample_value, req_sample_time));
         end
      end
      pending = expected_readings.size();
   end

endmodule

### tb/tb_per_sensor_running_average_unit.sv
`timescale 1ns / 100ps
// tb_per_sensor_running_average_unit: drives map and sample commands and limit writes
// into the running average unit over several idling phases; psra_checker scores results.
// Depends on psra_pkg, psra_checker and per_sensor_running_average_unit.
module tb_per_sensor_running_average_unit;
   import psra_pkg::*;

   localparam int MAX_SENSORS      = 16;
   localparam int WINDOW           = 8;
   localparam int PHASES           = 6;
   localparam int RANDOM_PER_PHASE = 120;
   localparam int CYCLE_LIMIT      = 400000;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_operation;
   logic [15:0]         req_sensor_id;
   logic [15:0]         req_room_id;
   logic signed [15:0]  req_sample_value;
   logic [31:0]         req_sample_time;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [15:0]         rsp_room_of_sensor;
   logic signed [15:0]  rsp_average;
   logic                rsp_too_hot;
   logic                rsp_too_cold;
   logic [31:0]         rsp_last_time;
   logic                csr_write;
   logic                csr_index;
   logic [15:0]         csr_wdata;

   int          fail_count;
   int          pending;
   int          idle_pct;
   int          maps_sent;
   int unsigned cycle_count;
   logic [15:0] known_ids[$];

   per_sensor_running_average_unit #(
      .MAX_SENSORS(MAX_SENSORS),
      .WINDOW     (WINDOW)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_sensor_id     (req_sensor_id),
      .req_room_id       (req_room_id),
      .req_sample_value  (req_sample_value),
      .req_sample_time   (req_sample_time),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_room_of_sensor(rsp_room_of_sensor),
      .rsp_average       (rsp_average),
      .rsp_too_hot       (rsp_too_hot),
      .rsp_too_cold      (rsp_too_cold),
      .rsp_last_time     (rsp_last_time),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   psra_checker #(
      .MAX_SENSORS(MAX_SENSORS),
      .WINDOW     (WINDOW)
   ) result_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_sensor_id     (req_sensor_id),
      .req_room_id       (req_room_id),
      .req_sample_value  (req_sample_value),
      .req_sample_time   (req_sample_time),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_room_of_sensor(rsp_room_of_sensor),
      .rsp_average       (rsp_average),
      .rsp_too_hot       (rsp_too_hot),
      .rsp_too_cold      (rsp_too_cold),
      .rsp_last_time     (rsp_last_time),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("per_sensor_running_average_unit test failed");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_command(input logic op, input logic [15:0] sid,
                               input logic [15:0] rid, input logic [15:0] val,
                               input logic [31:0] ts);
      while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_operation    <= op;
      req_sensor_id    <= sid;
      req_room_id      <= rid;
      req_sample_value <= val;
      req_sample_time  <= ts;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      if (op == OP_MAP) begin
         if (maps_sent < MAX_SENSORS) known_ids.push_back(sid);
         maps_sent++;
      end
   endtask

   task automatic send_random_command();
      int          pick;
      logic [15:0] val;
      pick = $urandom_range(99, 0);
      if ($urandom_range(9, 0) == 0) val = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
      else val = 16'($urandom);
      if (pick < 12) begin
         send_command(OP_MAP, 16'($urandom), 16'($urandom), val, $urandom);
      end else if (pick < 22) begin
         send_command(OP_SAMPLE, 16'($urandom), 16'($urandom), val, $urandom);
      end else begin
         send_command(OP_SAMPLE, known_ids[$urandom_range(known_ids.size() - 1, 0)],
                      16'($urandom), val, $urandom);
      end
   endtask

   task automatic wait_drained();
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_limits(input logic [15:0] low, input logic [15:0] high);
      csr_write <= 1'b1;
      csr_index <= CSR_LOW_LIMIT;
      csr_wdata <= low;
      @(negedge clock);
      csr_index <= CSR_HIGH_LIMIT;
      csr_wdata <= high;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int lo;
      reset            = 1'b1;
      start            = 1'b0;
      req_operation    = OP_MAP;
      req_sensor_id    = '0;
      req_room_id      = '0;
      req_sample_value = '0;
      req_sample_time  = '0;
      csr_write        = 1'b0;
      csr_index        = CSR_LOW_LIMIT;
      csr_wdata        = '0;
      idle_pct         = 0;
      maps_sent        = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sample into an empty table
      send_command(OP_SAMPLE, 16'h1234, 16'hFFFF, 16'h0000, 32'h0000_0000);
      send_command(OP_MAP, 16'h0000, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
      send_command(OP_MAP, 16'hFFFF, 16'h0000, 16'hFFFF, 32'h0000_0000);
      // duplicate id, lookups keep the first entry
      send_command(OP_MAP, 16'h0000, 16'h5A5A, 16'h0000, 32'h0000_0000);
      for (int i = 0; i < WINDOW; i++) begin
         send_command(OP_SAMPLE, 16'hFFFF, 16'h0000,
                      (i == WINDOW - 1) ? 16'h7FFF : 16'h8000, i);
      end
      send_command(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h8000, 32'hFFFF_FFFF);
      send_command(OP_SAMPLE, 16'h0000, 16'hFFFF, 16'h7FFF, 32'h0000_0001);
      for (int i = 0; i < MAX_SENSORS - 3; i++) begin
         send_command(OP_MAP, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end
      // table full
      send_command(OP_MAP, 16'hFFFF, 16'hFFFF, 16'h7FFF, 32'hFFFF_FFFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            start <= 1'b0;
            wait_drained();
            case (phase)
               1: write_limits(16'h8000, 16'h7FFF);
               2: write_limits(16'h7FFF, 16'h8000);
               3: begin
                  lo = $urandom_range(16000, 0) - 8000;
                  write_limits(lo[15:0], 16'(lo + $urandom_range(8000, 0)));
               end
               4: write_limits(16'h0000, 16'h0000);
               default: write_limits(16'($urandom), 16'($urandom));
            endcase
         end
         idle_pct = (phase % 3 == 1) ? 52 : (phase % 3 == 2) ? 7 : 0;
         repeat (RANDOM_PER_PHASE) send_random_command();
      end

      start <= 1'b0;
      wait_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0) $display("per_sensor_running_average_unit test passed");
      else $display("per_sensor_running_average_unit test failed");
      $finish;
   end

endmodule
